/* hw/rtl/ced_pkg.sv */
// ============================================================================
// ced_pkg: shared constants and types for the click energy-ratio detector
// Widths, fixed-point constants and configuration register indexes.
// ============================================================================
`default_nettype none

package ced_pkg;

    localparam int MAX_WINDOW_DEF   = 8192;
    localparam int COUNTER_BITS_DEF = 40;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int POWER_W  = 2 * SAMPLE_W;
    localparam int CFG_W    = 16;
    localparam int WLEN_W   = 14;
    localparam int SCORE_W  = 16;
    localparam int START_W  = 41;
    localparam int RUN_W    = 24;
    localparam int OUT_W    = 72;

    // log2 mantissa in Q1.30, 16 fraction bits of result
    localparam int MANT_W   = 31;
    localparam int FRAC_W   = 16;
    localparam int LOGDIFF_W = 24;
    localparam int DBC_W    = 19;
    localparam int DBPROD_W = LOGDIFF_W + DBC_W;

    localparam logic signed [DBC_W-1:0] DB_PER_OCTAVE_Q16 = 19'sd197283;
    localparam logic [RUN_W-1:0]        RUN_MAX           = {RUN_W{1'b1}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX       = 16'sh7FFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN       = 16'sh8000;
    localparam logic [WLEN_W-1:0]       WINDOW_RESET      = 14'd5000;
    localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 16'sd768;

    typedef enum logic {
        REG_WINDOW    = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_index_t;

endpackage : ced_pkg

`default_nettype wire

/* hw/rtl/ced_log2.sv */
// ============================================================================
// ced_log2: iterative log2 in Q.16
// Binary-search normalize, then 16 mantissa squarings, each a multiply state followed by a fix state.
// ============================================================================
`default_nettype none

module ced_log2 #(
    parameter int W = 46
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [W-1:0]                    x,
    output logic                                 done,
    output logic [$clog2(W)+ced_pkg::FRAC_W-1:0] result
);
    import ced_pkg::*;

    localparam int EW = $clog2(W);
    localparam int K  = $clog2(W);
    localparam int KW = (K > 1) ? $clog2(K) : 1;
    localparam int PW = 2 * MANT_W;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_MUL  = 4'b0100,
        L_FIX  = 4'b1000
    } lstate_t;

    lstate_t            state_reg;
    logic [W-1:0]       x_reg;
    logic [EW-1:0]      e_reg;
    logic [KW-1:0]      k_reg;
    logic [MANT_W-1:0]  m_reg;
    logic [PW-1:0]      prod_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [3:0]         it_reg;
    logic               done_reg;
    logic               top_zero;
    logic [EW-1:0]      sh;
    logic [MANT_W:0]    sq;

    always_comb begin
        int s;
        s        = 1 << k_reg;
        sh       = EW'(s);
        top_zero = ((x_reg >> (W - s)) == '0);
        sq       = prod_reg[PW-1:MANT_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        x_reg     <= x;
                        e_reg     <= EW'(W - 1);
                        k_reg     <= KW'(K - 1);
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (top_zero) begin
                        x_reg <= x_reg << sh;
                        e_reg <= e_reg - sh;
                    end
                    if (k_reg == '0) begin
                        m_reg     <= top_zero ? MANT_W'((x_reg << sh) >> (W - MANT_W))
                                              : MANT_W'(x_reg >> (W - MANT_W));
                        state_reg <= L_MUL;
                    end else begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                L_MUL: begin
                    prod_reg  <= m_reg * m_reg;
                    state_reg <= L_FIX;
                end
                L_FIX: begin
                    if (sq[MANT_W]) begin
                        m_reg    <= sq[MANT_W:1];
                        frac_reg <= {frac_reg[FRAC_W-2:0], 1'b1};
                    end else begin
                        m_reg    <= sq[MANT_W-1:0];
                        frac_reg <= {frac_reg[FRAC_W-2:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 4'd15) begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end else begin
                        state_reg <= L_MUL;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule : ced_log2

`default_nettype wire

/* hw/rtl/click_energy_ratio_detector.sv */
// ============================================================================
// click_energy_ratio_detector: energy-ratio click detector
// Three chained power windows, dB score, run tracking and event output.
// ============================================================================
// One sample is taken at a time; a new sample is accepted only once the last
// one is through: accept, memory update, log start, then the two log2 units
// running side by side (six normalize steps plus sixteen multiply-and-fix
// mantissa squarings), then the done check, the dB multiply and the score
// step. The three delay lines share one block memory, one entry
// per ring slot holding the before, during and after values; entries not
// yet written since reset or a window_length write read as zero through a
// ring-wrap flag, so there is no clearing pass. A finished event waits in
// the output register while the next sample is processed; the block holds
// its score step only if a second event arrives before the first is taken.
`default_nettype none

module click_energy_ratio_detector #(
    parameter int MAX_WINDOW   = ced_pkg::MAX_WINDOW_DEF,
    parameter int COUNTER_BITS = ced_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: [15:0] sample
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ced_pkg::SAMPLE_W-1:0] s_tdata,
    // m_tdata: [40:0] event_start, [54:41] event_length,
    //          [70:55] peak_score_db, [71] zero
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [ced_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [ced_pkg::CFG_W-1:0]    cfg_data
);
    import ced_pkg::*;

    localparam int PW    = $clog2(MAX_WINDOW);       // ring position
    localparam int NW    = $clog2(MAX_WINDOW + 1);   // window length
    localparam int SUM_W = POWER_W + PW;
    localparam int LW    = SUM_W + 1;                // log operand
    localparam int RW    = $clog2(LW) + FRAC_W;
    localparam int EXW   = (COUNTER_BITS > START_W ? COUNTER_BITS : START_W) + 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_UPD   = 6'b000010,
        ST_LOG   = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_SCORE = 6'b100000
    } state_t;

    state_t                      state_reg;
    logic [NW-1:0]               win_reg;
    logic signed [SCORE_W-1:0]   thr_reg;
    logic signed [SAMPLE_W-1:0]  prev_reg;
    logic [COUNTER_BITS-1:0]     cnt_reg;
    logic [COUNTER_BITS-1:0]     now_reg;
    logic [POWER_W-1:0]          power_reg;
    logic [PW-1:0]               pos_reg;
    logic [PW-1:0]               q_reg;
    logic                        full_reg;
    logic                        rd_valid_reg;
    logic [SUM_W-1:0]            before_reg, during_reg, after_reg;
    logic [RUN_W-1:0]            run_reg;
    logic signed [SCORE_W-1:0]   peak_reg;
    logic [RUN_W-1:0]            poff_reg;
    logic signed [LOGDIFF_W-1:0] ldiff_reg;
    logic signed [DBPROD_W-1:0]  dbp_reg;
    logic                        m_tvalid_reg;
    logic [OUT_W-1:0]            m_tdata_reg;

    // delay line memory: {after, during, before} per ring slot
    logic [3*POWER_W-1:0] dline_mem [MAX_WINDOW];
    logic [3*POWER_W-1:0] dline_rd_reg;

    logic                       accept;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] diff_sq;
    logic [PW-1:0]              q_next;
    logic [POWER_W-1:0]         bq, dq, aq;
    logic [LW-1:0]              num, den;
    logic                       ln_done, ld_done;
    logic [RW-1:0]              ln_res, ld_res;
    logic signed [DBPROD_W-1:0] t_round;
    logic signed [DBPROD_W-1:0] q_db;
    logic signed [SCORE_W-1:0]  score;
    logic                       above, emit, stall, load_out;
    logic [NW-1:0]              win_wr;
    logic [EXW-1:0]             start_full;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign diff     = DIFF_W'($signed(s_tdata)) - DIFF_W'(prev_reg);
    assign diff_sq  = diff * diff;

    // successor slot, wrapping at the window end
    assign q_next = ({1'b0, pos_reg} + 1'b1 >= (PW+1)'(win_reg)) ? '0 : pos_reg + 1'b1;

    // slots never written since the last restart read as zero
    assign bq = rd_valid_reg ? dline_rd_reg[POWER_W-1:0] : '0;
    assign dq = rd_valid_reg ? dline_rd_reg[2*POWER_W-1:POWER_W] : '0;
    assign aq = rd_valid_reg ? dline_rd_reg[3*POWER_W-1:2*POWER_W] : '0;

    assign num = {during_reg, 1'b0};
    assign den = LW'(before_reg) + LW'(after_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            dline_rd_reg <= dline_mem[q_next];
        end
        if (state_reg == ST_UPD) begin
            dline_mem[pos_reg] <= {dq, bq, power_reg};
        end
    end

    ced_log2 #(.W(LW)) u_log_num (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (state_reg == ST_LOG),
        .x      (num),
        .done   (ln_done),
        .result (ln_res)
    );

    ced_log2 #(.W(LW)) u_log_den (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (state_reg == ST_LOG),
        .x      (den),
        .done   (ld_done),
        .result (ld_res)
    );

    // dB score: round to nearest, floor shift, saturate; zero cases override
    always_comb begin
        t_round = dbp_reg + (DBPROD_W'(1) <<< 23);
        q_db    = t_round >>> 24;
        if (den == '0) begin
            score = (num != '0) ? SCORE_MAX : SCORE_MIN;
        end else if (num == '0) begin
            score = SCORE_MIN;
        end else if (q_db > DBPROD_W'(SCORE_MAX)) begin
            score = SCORE_MAX;
        end else if (q_db < DBPROD_W'(SCORE_MIN)) begin
            score = SCORE_MIN;
        end else begin
            score = q_db[SCORE_W-1:0];
        end
        above = (score > thr_reg);
        emit  = !above && (run_reg != '0) && (run_reg > RUN_W'(win_reg >> 2));
        stall = emit && m_tvalid_reg && !m_tready;
        load_out = (state_reg == ST_SCORE) && emit && !stall;
        start_full = EXW'(now_reg) - EXW'(poff_reg) - (EXW'(win_reg) << 1);
    end

    // window write: 14-bit field, zero means one, clamp to the memory depth
    always_comb begin
        if (cfg_data[WLEN_W-1:0] == '0) begin
            win_wr = NW'(1);
        end else if (32'(cfg_data[WLEN_W-1:0]) > 32'(MAX_WINDOW)) begin
            win_wr = NW'(MAX_WINDOW);
        end else begin
            win_wr = NW'(cfg_data[WLEN_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            win_reg      <= NW'(WINDOW_RESET);
            thr_reg      <= THRESHOLD_RESET;
            prev_reg     <= '0;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            before_reg   <= '0;
            during_reg   <= '0;
            after_reg    <= '0;
            run_reg      <= '0;
            peak_reg     <= '0;
            poff_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new event takes the output register only once it is free
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    REG_WINDOW: begin
                        win_reg    <= win_wr;
                        pos_reg    <= '0;
                        full_reg   <= 1'b0;
                        before_reg <= '0;
                        during_reg <= '0;
                        after_reg  <= '0;
                        run_reg    <= '0;
                        peak_reg   <= '0;
                        poff_reg   <= '0;
                    end
                    REG_THRESHOLD: thr_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        power_reg    <= diff_sq[POWER_W-1:0];
                        prev_reg     <= $signed(s_tdata);
                        now_reg      <= cnt_reg;
                        cnt_reg      <= cnt_reg + 1'b1;
                        q_reg        <= q_next;
                        rd_valid_reg <= full_reg || (q_next < pos_reg);
                        state_reg    <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    // window of one: sums stay zero
                    if (win_reg != NW'(1)) begin
                        before_reg <= before_reg + SUM_W'(power_reg) - SUM_W'(bq);
                        during_reg <= during_reg + SUM_W'(bq) - SUM_W'(dq);
                        after_reg  <= after_reg + SUM_W'(dq) - SUM_W'(aq);
                    end
                    pos_reg <= q_reg;
                    if (q_reg == '0) begin
                        full_reg <= 1'b1;
                    end
                    state_reg <= ST_LOG;
                end
                ST_LOG: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (ln_done) begin
                        ldiff_reg <= LOGDIFF_W'(65536) + $signed(LOGDIFF_W'(ln_res))
                                     - $signed(LOGDIFF_W'(ld_res));
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    dbp_reg   <= ldiff_reg * DB_PER_OCTAVE_Q16;
                    state_reg <= ST_SCORE;
                end
                ST_SCORE: begin
                    if (!stall) begin
                        if (above) begin
                            if (run_reg == '0) begin
                                run_reg  <= RUN_W'(1);
                                peak_reg <= score;
                                poff_reg <= '0;
                            end else begin
                                if (run_reg < RUN_MAX) begin
                                    run_reg <= run_reg + 1'b1;
                                end
                                if (score > peak_reg) begin
                                    peak_reg <= score;
                                    poff_reg <= (run_reg < RUN_MAX) ? run_reg + 1'b1 : run_reg;
                                end
                            end
                        end else begin
                            run_reg <= '0;
                        end
                        if (emit) begin
                            m_tdata_reg  <= {1'b0, peak_reg, WLEN_W'(win_reg),
                                             start_full[START_W-1:0]};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW+1)'(pos_reg) < (NW+1)'(win_reg))
        else $error("ring position outside window");

    a_logs_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ln_done == ld_done)
        else $error("log units out of step");

    a_wrap_flag_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(full_reg) |-> $past(cfg_we && (cfg_index == REG_WINDOW)))
        else $error("wrap flag cleared without a window write");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready && state_reg == ST_SCORE && emit) |=> $stable(m_tdata_reg))
        else $error("pending event overwritten");

endmodule : click_energy_ratio_detector

`default_nettype wire

/* verif/tb.sv */
// ============================================================================
// tb: click energy-ratio detector testbench
// Streams audio samples into the detector. Each accepted transaction goes
// through an in-bench model of the three energy windows, the dB score and
// the run tracking, and the resulting click events are checked field by
// field in order. Window and threshold settings change between phases.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ced_pkg::*;

    localparam int MAXW       = 8192;
    localparam int IDLE_LIMIT = 20000;  // cycles with no transaction at all
    localparam int SETTLE     = 200;    // well over one sample's latency
    localparam int HOLD_LEN   = 3000;   // long receiver hold-off

    typedef struct {
        logic [START_W-1:0] start;
        logic [WLEN_W-1:0]  len;
        logic [SCORE_W-1:0] peak;
    } click_event_t;

    // ------------------------------------------------------------------
    // Detector model and event scoreboard
    // ------------------------------------------------------------------
    class click_scoreboard;
        int unsigned       win_len;
        int                thresh;
        longint            prev_smp;
        longint unsigned   pwr_line[3*MAXW];
        longint unsigned   sum_b, sum_d, sum_a;
        int unsigned       ring_pos;
        int unsigned       run_len;
        int                peak_db;
        int unsigned       peak_off;
        longint unsigned   smp_count;
        click_event_t      pending_events[$];
        int                errors;

        function new();
            win_len = WINDOW_RESET;
            thresh = THRESHOLD_RESET;
            prev_smp = 0;
            smp_count = 0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (pwr_line[i]) pwr_line[i] = 0;
            sum_b = 0;
            sum_d = 0;
            sum_a = 0;
            ring_pos = 0;
            run_len = 0;
            peak_db = 0;
            peak_off = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            int unsigned w;
            if (idx == REG_WINDOW) begin
                w = val[WLEN_W-1:0];
                if (w == 0) w = 1;
                if (w > MAXW) w = MAXW;
                win_len = w;
                restart();
            end else begin
                thresh = $signed(val);
            end
        endfunction

        // log2 in Q.16: leading-one position plus 16 squaring steps
        function longint log2_q16(longint unsigned x);
            int e;
            longint unsigned m;
            longint frac;
            e = 63;
            frac = 0;
            while (e > 0 && x[e] == 1'b0) e--;
            if (e >= 30) m = x >> (e - 30);
            else m = x << (30 - e);
            for (int i = 0; i < FRAC_W; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    frac = frac | 1;
                end
            end
            return (longint'(e) << 16) + frac;
        endfunction

        function int ratio_db(longint unsigned num, longint unsigned den);
            longint l, t, q;
            if (den == 0) return (num != 0) ? 32767 : -32768;
            if (num == 0) return -32768;
            l = 65536 + log2_q16(num) - log2_q16(den);
            t = l * 197283 + (64'sd1 <<< 23);
            q = t >>> 24;   // floor division
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return int'(q);
        endfunction

        // one accepted sample transaction
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            longint x, diff;
            longint unsigned pwr, now;
            int unsigned p, q;
            int score;
            click_event_t ev;
            x = longint'($signed(smp));
            diff = x - prev_smp;
            pwr = longint'(diff * diff);
            now = smp_count;
            prev_smp = x;
            smp_count = (smp_count + 1) & ((64'd1 << 40) - 1);

            p = ring_pos;
            if (p >= win_len) p = 0;
            q = (p + 1 >= win_len) ? 0 : p + 1;
            pwr_line[p] = pwr;
            pwr_line[MAXW + p] = pwr_line[q];
            pwr_line[2*MAXW + p] = pwr_line[MAXW + q];
            sum_b += pwr_line[p] - pwr_line[q];
            sum_d += pwr_line[MAXW + p] - pwr_line[MAXW + q];
            sum_a += pwr_line[2*MAXW + p] - pwr_line[2*MAXW + q];
            ring_pos = q;

            score = ratio_db(2 * sum_d, sum_b + sum_a);
            if (score > thresh) begin
                if (run_len == 0) begin
                    run_len = 1;
                    peak_db = score;
                    peak_off = 0;
                end else begin
                    if (run_len < RUN_MAX) run_len++;
                    if (score > peak_db) begin
                        peak_db = score;
                        peak_off = run_len;
                    end
                end
                return;
            end
            if (run_len == 0) return;
            if (run_len > win_len / 4) begin
                ev.start = START_W'(longint'(now) - longint'(peak_off)
                                    - 2 * longint'(win_len));
                ev.len = WLEN_W'(win_len);
                ev.peak = SCORE_W'(peak_db);
                pending_events.push_back(ev);
            end
            run_len = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // one accepted event transaction
        task check_event(logic [OUT_W-1:0] d);
            click_event_t ev;
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected event, tdata=%h", d));
                return;
            end
            ev = pending_events.pop_front();
            if (d[40:0] !== ev.start)
                report($sformatf("event_start got %h want %h", d[40:0], ev.start));
            if (d[54:41] !== ev.len)
                report($sformatf("event_length got %0d want %0d", d[54:41], ev.len));
            if (d[70:55] !== ev.peak)
                report($sformatf("peak_score_db got %h want %h", d[70:55], ev.peak));
            if (d[71] !== 1'b0)
                report("tdata pad bit set");
        endtask

        function int outstanding();
            return pending_events.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;   // [15:0] sample
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;        // [40:0] start, [54:41] length, [70:55] peak
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;

    click_energy_ratio_detector uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    click_scoreboard sb = new();

    initial begin
        forever #5 aclk = ~aclk;
    end

    // knobs shared by the stimulus and the receiver
    bit steady_flow = 1'b0;    // no idling on either side
    int hold_asked = 0;        // bumped by stimulus to ask for a long hold-off
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    // ------------------------------------------------------------------
    // Receiver: random backpressure, occasional long stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady_flow) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(20, 300);
            m_tready <= ($urandom_range(0, 99) < 75);
        end
    end

    // event monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_event(m_tdata);
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    task automatic send_sample(logic [SAMPLE_W-1:0] smp);
        int gap;
        int r;
        gap = 0;
        if (!steady_flow) begin
            r = $urandom_range(0, 99);
            if (r < 25) gap = $urandom_range(1, 3);
            else if (r < 29) gap = $urandom_range(20, 200);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp);
        items_sent++;
    endtask

    // wait for every expected event, then let the block go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // quiet stretch around a base level, then a short loud click
    task automatic quiet_then_click(int unsigned wlen, int noise);
        int base;
        int quiet;
        base = $urandom_range(0, 2000) - 1000;
        quiet = $urandom_range(2 * wlen, 4 * wlen);
        repeat (quiet) send_sample(SAMPLE_W'(base + $urandom_range(0, noise)));
        repeat ($urandom_range(1, 3)) send_sample(SAMPLE_W'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned wlen;
        int target;
        int unsigned wchoices[9];

        wchoices = '{2, 3, 4, 5, 8, 12, 16, 24, 32};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: extremes of the sample and full-swing differences
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
        send_sample(16'h8000);
        drain();

        // zero window acts as one: sums stay zero, no events
        write_reg(REG_WINDOW, 16'h0000);
        write_reg(REG_THRESHOLD, 16'sh8000);
        repeat (5) send_sample(SAMPLE_W'($urandom()));
        drain();

        // window two, lowest threshold: everything above floor counts
        write_reg(REG_WINDOW, 16'h0002);
        repeat (6) send_sample(SAMPLE_W'($urandom()));
        send_sample(16'h0000);
        send_sample(16'h0000);
        drain();

        // highest threshold: nothing can exceed it
        write_reg(REG_THRESHOLD, 16'sh7FFF);
        repeat (4) send_sample(SAMPLE_W'($urandom()));
        drain();

        // oversized window saturates to the maximum; upper data bits ignored
        write_reg(REG_THRESHOLD, 16'sd768);
        write_reg(REG_WINDOW, 16'hFFFF);
        repeat (40) send_sample(SAMPLE_W'($urandom()));
        drain();

        // fill-up: receiver holds off while clicks keep producing events
        write_reg(REG_WINDOW, 16'h4004);   // window 4, stray upper bits
        write_reg(REG_THRESHOLD, 16'sd0);
        hold_asked++;
        repeat (12) quiet_then_click(4, 0);
        drain();                           // sender pauses until all are in

        // random phases: mostly clean click patterns, some raw noise
        target = 1100;
        while (items_sent < target) begin
            wlen = wchoices[$urandom_range(0, 8)];
            write_reg(REG_WINDOW, CFG_W'(wlen) | (CFG_W'($urandom_range(0, 3)) << 14));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_THRESHOLD, CFG_W'($urandom()));
            else
                write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 3000)));
            steady_flow = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 6)) begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(5, 30)) send_sample(SAMPLE_W'($urandom()));
                else
                    quiet_then_click(wlen, $urandom_range(0, 4));
            end
            drain();
            steady_flow = 1'b0;
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
